### rtl/grm_pkg.sv
// shared types, constants and the control program of the ray marcher
`default_nettype none

package grm_pkg;

	localparam int FRAC_BITS = 24;
	localparam int WORD_BITS = 32;
	localparam int FIELD_W   = 32;
	localparam int WIDE_W    = 64 - FRAC_BITS;
	localparam int MAG_W     = 62 - FRAC_BITS;
	localparam int NUM_W     = MAG_W + FRAC_BITS;

	localparam int STEP_W = 25;
	localparam int MAXS_W = 8;
	localparam int CAP_W  = 29;
	localparam int CFG_W  = 29;
	localparam int CIDX_W = 2;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [CIDX_W-1:0] cidx_t;

	localparam wide_t WIDE_LIM = wide_t'((64'd1 << MAG_W) - 64'd1);
	localparam wide_t ONE_Q    = wide_t'(64'd1 << FRAC_BITS);
	localparam wide_t WORD_MAX = wide_t'((64'd1 << (WORD_BITS - 1)) - 64'd1);
	localparam wide_t WORD_MIN = -WORD_MAX - wide_t'(1);

	localparam cidx_t CFG_STEP = 2'd0;
	localparam cidx_t CFG_MAXS = 2'd1;
	localparam cidx_t CFG_CAP  = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RST = 25'd838861;
	localparam logic [MAXS_W-1:0] MAXS_RST = 8'd200;
	localparam logic [CAP_W-1:0]  CAP_RST  = 29'd20132659;

	typedef logic [4:0] addr_t;
	typedef logic [6:0] pc_t;

	// register file slots; the first seven are the result fields
	localparam addr_t A_X  = 5'd0;
	localparam addr_t A_Y  = 5'd1;
	localparam addr_t A_Z  = 5'd2;
	localparam addr_t A_VT = 5'd3;
	localparam addr_t A_VX = 5'd4;
	localparam addr_t A_VY = 5'd5;
	localparam addr_t A_VZ = 5'd6;
	localparam addr_t A_R2 = 5'd7;
	localparam addr_t A_R  = 5'd8;
	localparam addr_t A_M  = 5'd9;
	localparam addr_t A_S  = 5'd10;
	localparam addr_t A_V2 = 5'd11;
	localparam addr_t A_U  = 5'd12;
	localparam addr_t A_Q  = 5'd13;
	localparam addr_t A_UU = 5'd14;
	localparam addr_t A_T1 = 5'd15;
	localparam addr_t A_T2 = 5'd16;
	localparam addr_t A_T3 = 5'd17;
	localparam addr_t A_T4 = 5'd18;
	localparam addr_t A_FS = 5'd19;
	localparam addr_t A_A0 = 5'd20;
	localparam addr_t A_E1 = 5'd21;
	localparam addr_t A_E2 = 5'd22;
	localparam addr_t A_H  = 5'd23;
	localparam int RF_DEPTH = 24;
	localparam int NRES     = 7;

	// input field selects for the load op
	localparam addr_t F_SX = 5'd0;
	localparam addr_t F_SY = 5'd1;
	localparam addr_t F_SZ = 5'd2;
	localparam addr_t F_DX = 5'd3;
	localparam addr_t F_DY = 5'd4;
	localparam addr_t F_DZ = 5'd5;
	localparam int NIN = 6;

	typedef enum logic [3:0] {
		OP_NOP, OP_LDIN, OP_ADD, OP_NEG, OP_HALF, OP_DECM, OP_CLW,
		OP_MUL, OP_DIV, OP_SQRT, OP_SETM, OP_STEP, OP_FINISH
	} op_t;

	typedef enum logic [1:0] {C_ALWAYS, C_MARCH, C_LIMIT, C_CAUGHT} cond_t;

	typedef enum logic [1:0] {MD_MUL, MD_DIV, MD_SQRT} mdu_op_t;

	typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_FINISH} seq_state_t;

	typedef struct packed {
		op_t   op;
		addr_t dst;
		addr_t sa;
		addr_t sb;
		cond_t cond;
		pc_t   target;
	} cw_t;

	typedef struct packed {
		logic              idle;
		logic              rd;
		logic              wr_alu;
		logic              mdu_go;
		logic              wr_mdu;
		logic              out_load;
		logic              caught;
		logic [MAXS_W-1:0] steps;
	} ctl_t;

	typedef struct packed {
		logic mdu_done;
		logic capt;
		logic out_free;
	} sts_t;

	localparam pc_t PC_RADIAL = 7'd6;
	localparam pc_t PC_CHECK  = 7'd33;
	localparam pc_t PC_MARCH  = 7'd35;
	localparam pc_t PC_DONE   = 7'd85;

	function automatic wide_t sat_wide(input logic signed [WIDE_W:0] a);
		logic signed [WIDE_W:0] lim;
		lim = {1'b0, WIDE_LIM};
		if (a > lim) return WIDE_LIM;
		if (a < -lim) return -WIDE_LIM;
		return a[WIDE_W-1:0];
	endfunction

	function automatic wide_t clamp_word(input wide_t a);
		if (a > WORD_MAX) return WORD_MAX;
		if (a < WORD_MIN) return WORD_MIN;
		return a;
	endfunction

	function automatic cw_t ins(input op_t o, input addr_t d, input addr_t a, input addr_t b);
		cw_t c;
		c = '{op: o, dst: d, sa: a, sb: b, cond: C_ALWAYS, target: '0};
		return c;
	endfunction

	function automatic cw_t jmp(input cond_t cnd, input pc_t t);
		cw_t c;
		c = '{op: OP_NOP, dst: A_E1, sa: A_E1, sb: A_E1, cond: cnd, target: t};
		return c;
	endfunction

	function automatic cw_t ucode(input pc_t pc);
		cw_t c;
		case (pc)
			7'd0:  c = ins(OP_LDIN, A_X,  F_SX, A_E1);
			7'd1:  c = ins(OP_LDIN, A_Y,  F_SY, A_E1);
			7'd2:  c = ins(OP_LDIN, A_Z,  F_SZ, A_E1);
			7'd3:  c = ins(OP_LDIN, A_VX, F_DX, A_E1);
			7'd4:  c = ins(OP_LDIN, A_VY, F_DY, A_E1);
			7'd5:  c = ins(OP_LDIN, A_VZ, F_DZ, A_E1);
			// radius and dot products
			7'd6:  c = ins(OP_MUL,  A_E1, A_X,  A_X);
			7'd7:  c = ins(OP_MUL,  A_E2, A_Y,  A_Y);
			7'd8:  c = ins(OP_ADD,  A_E1, A_E1, A_E2);
			7'd9:  c = ins(OP_MUL,  A_E2, A_Z,  A_Z);
			7'd10: c = ins(OP_ADD,  A_R2, A_E1, A_E2);
			7'd11: c = ins(OP_SQRT, A_R,  A_R2, A_R2);
			7'd12: c = ins(OP_DECM, A_M,  A_R,  A_R);
			7'd13: c = ins(OP_MUL,  A_S,  A_X,  A_VX);
			7'd14: c = ins(OP_MUL,  A_E1, A_Y,  A_VY);
			7'd15: c = ins(OP_ADD,  A_S,  A_S,  A_E1);
			7'd16: c = ins(OP_MUL,  A_E1, A_Z,  A_VZ);
			7'd17: c = ins(OP_ADD,  A_S,  A_S,  A_E1);
			7'd18: c = ins(OP_MUL,  A_V2, A_VX, A_VX);
			7'd19: c = ins(OP_MUL,  A_E1, A_VY, A_VY);
			7'd20: c = ins(OP_ADD,  A_V2, A_V2, A_E1);
			7'd21: c = ins(OP_MUL,  A_E1, A_VZ, A_VZ);
			7'd22: c = ins(OP_ADD,  A_V2, A_V2, A_E1);
			7'd23: c = jmp(C_MARCH, PC_MARCH);
			// lightlike time velocity
			7'd24: c = ins(OP_DIV,  A_E1, A_S,  A_R2);
			7'd25: c = ins(OP_MUL,  A_E1, A_E1, A_S);
			7'd26: c = ins(OP_DIV,  A_E1, A_E1, A_M);
			7'd27: c = ins(OP_ADD,  A_E1, A_V2, A_E1);
			7'd28: c = ins(OP_DIV,  A_E2, A_R,  A_M);
			7'd29: c = ins(OP_MUL,  A_E1, A_E1, A_E2);
			7'd30: c = ins(OP_SQRT, A_E1, A_E1, A_E1);
			7'd31: c = ins(OP_CLW,  A_VT, A_E1, A_E1);
			7'd32: c = ins(OP_SETM, A_E1, A_E1, A_E1);
			7'd33: c = jmp(C_LIMIT, PC_DONE);
			7'd34: c = jmp(C_ALWAYS, PC_RADIAL);
			// acceleration
			7'd35: c = ins(OP_DIV,  A_U,  A_S,  A_R2);
			7'd36: c = ins(OP_DIV,  A_Q,  A_VT, A_R2);
			7'd37: c = ins(OP_MUL,  A_UU, A_U,  A_U);
			7'd38: c = ins(OP_MUL,  A_E1, A_Q,  A_Q);
			7'd39: c = ins(OP_MUL,  A_E1, A_M,  A_E1);
			7'd40: c = ins(OP_HALF, A_T1, A_E1, A_E1);
			7'd41: c = ins(OP_DIV,  A_E1, A_UU, A_M);
			7'd42: c = ins(OP_HALF, A_T2, A_E1, A_E1);
			7'd43: c = ins(OP_DIV,  A_E1, A_V2, A_R2);
			7'd44: c = ins(OP_DIV,  A_T3, A_E1, A_R);
			7'd45: c = ins(OP_DIV,  A_T4, A_UU, A_R);
			7'd46: c = ins(OP_ADD,  A_E1, A_T2, A_T4);
			7'd47: c = ins(OP_ADD,  A_E2, A_T1, A_T3);
			7'd48: c = ins(OP_NEG,  A_E2, A_E2, A_E2);
			7'd49: c = ins(OP_ADD,  A_FS, A_E1, A_E2);
			7'd50: c = ins(OP_DIV,  A_E1, A_U,  A_M);
			7'd51: c = ins(OP_MUL,  A_E1, A_VT, A_E1);
			7'd52: c = ins(OP_NEG,  A_A0, A_E1, A_E1);
			// velocity update
			7'd53: c = ins(OP_MUL,  A_E1, A_A0, A_H);
			7'd54: c = ins(OP_ADD,  A_E1, A_VT, A_E1);
			7'd55: c = ins(OP_CLW,  A_VT, A_E1, A_E1);
			7'd56: c = ins(OP_MUL,  A_E1, A_X,  A_FS);
			7'd57: c = ins(OP_MUL,  A_E1, A_E1, A_H);
			7'd58: c = ins(OP_ADD,  A_E1, A_VX, A_E1);
			7'd59: c = ins(OP_CLW,  A_VX, A_E1, A_E1);
			7'd60: c = ins(OP_MUL,  A_E1, A_Y,  A_FS);
			7'd61: c = ins(OP_MUL,  A_E1, A_E1, A_H);
			7'd62: c = ins(OP_ADD,  A_E1, A_VY, A_E1);
			7'd63: c = ins(OP_CLW,  A_VY, A_E1, A_E1);
			7'd64: c = ins(OP_MUL,  A_E1, A_Z,  A_FS);
			7'd65: c = ins(OP_MUL,  A_E1, A_E1, A_H);
			7'd66: c = ins(OP_ADD,  A_E1, A_VZ, A_E1);
			7'd67: c = ins(OP_CLW,  A_VZ, A_E1, A_E1);
			// position update
			7'd68: c = ins(OP_MUL,  A_E1, A_VX, A_H);
			7'd69: c = ins(OP_ADD,  A_E1, A_X,  A_E1);
			7'd70: c = ins(OP_CLW,  A_X,  A_E1, A_E1);
			7'd71: c = ins(OP_MUL,  A_E1, A_VY, A_H);
			7'd72: c = ins(OP_ADD,  A_E1, A_Y,  A_E1);
			7'd73: c = ins(OP_CLW,  A_Y,  A_E1, A_E1);
			7'd74: c = ins(OP_MUL,  A_E1, A_VZ, A_H);
			7'd75: c = ins(OP_ADD,  A_E1, A_Z,  A_E1);
			7'd76: c = ins(OP_CLW,  A_Z,  A_E1, A_E1);
			// capture test
			7'd77: c = ins(OP_MUL,  A_E1, A_X,  A_X);
			7'd78: c = ins(OP_MUL,  A_E2, A_Y,  A_Y);
			7'd79: c = ins(OP_ADD,  A_E1, A_E1, A_E2);
			7'd80: c = ins(OP_MUL,  A_E2, A_Z,  A_Z);
			7'd81: c = ins(OP_ADD,  A_E1, A_E1, A_E2);
			7'd82: c = ins(OP_STEP, A_E1, A_E1, A_E1);
			7'd83: c = jmp(C_CAUGHT, PC_DONE);
			7'd84: c = jmp(C_ALWAYS, PC_CHECK);
			default: c = ins(OP_FINISH, A_E1, A_E1, A_E1);
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/grm_mdu.sv
// iterative multiply, divide and square root unit on wide fixed point
`default_nettype none

module grm_mdu (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  grm_pkg::mdu_op_t op,
	input  grm_pkg::wide_t   a,
	input  grm_pkg::wide_t   b,
	output logic             done,
	output grm_pkg::wide_t   res
);
	import grm_pkg::*;

	localparam int NCH   = (MAG_W + 7) / 8;
	localparam int MUL_W = NCH * 8;
	localparam int ACC_W = MUL_W + MAG_W;
	localparam int REM_W = MAG_W + 2;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	mdu_op_t          op_q;
	logic [MAG_W-1:0] dv_q;
	logic [NUM_W-1:0] sh_q;
	logic [ACC_W-1:0] acc_q;
	logic [REM_W-1:0] rem_q;
	wide_t            res_q;

	wide_t            abs_a, abs_b;
	logic [MAG_W-1:0] ma, mb;
	logic [MAG_W+7:0] pp;
	logic [ACC_W-1:0] acc_mul;
	logic [REM_W-1:0] t_div, t_sq, trial;
	logic             ge_div, ge_sq;
	logic [ACC_W-FRAC_BITS-1:0] p_mul;
	logic [MAG_W-1:0] mag_fin;
	wide_t            res_fin;

	always_comb begin
		abs_a = a[WIDE_W-1] ? -a : a;
		abs_b = b[WIDE_W-1] ? -b : b;
		ma    = abs_a[MAG_W-1:0];
		mb    = abs_b[MAG_W-1:0];
	end

	// one step of each operation
	always_comb begin
		pp      = dv_q * sh_q[NUM_W-1 -: 8];
		acc_mul = (acc_q << 8) + {{(MUL_W-8){1'b0}}, pp};
		t_div   = {rem_q[REM_W-2:0], sh_q[NUM_W-1]};
		ge_div  = t_div >= {2'b00, dv_q};
		t_sq    = {rem_q[REM_W-3:0], sh_q[NUM_W-1 -: 2]};
		trial   = {acc_q[REM_W-3:0], 2'b01};
		ge_sq   = t_sq >= trial;
	end

	// final scaling and saturation
	always_comb begin
		p_mul = acc_q[ACC_W-1:FRAC_BITS];
		case (op_q)
			MD_MUL:  mag_fin = (|p_mul[ACC_W-FRAC_BITS-1:MAG_W]) ? '1 : p_mul[MAG_W-1:0];
			MD_DIV:  mag_fin = (|acc_q[NUM_W-1:MAG_W]) ? '1 : acc_q[MAG_W-1:0];
			default: mag_fin = acc_q[MAG_W-1:0];
		endcase
		res_fin = neg_q ? -wide_t'(mag_fin) : wide_t'(mag_fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				unique case (op)
					MD_MUL: begin
						busy_q <= 1'b1;
						cnt_q  <= CNT_W'(NCH);
					end
					MD_DIV: begin
						if (mb == '0) done_q <= 1'b1;
						else begin
							busy_q <= 1'b1;
							cnt_q  <= CNT_W'(NUM_W);
						end
					end
					default: begin
						if (a < wide_t'(1)) done_q <= 1'b1;
						else begin
							busy_q <= 1'b1;
							cnt_q  <= CNT_W'(NUM_W / 2);
						end
					end
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q  <= op;
			neg_q <= a[WIDE_W-1] ^ b[WIDE_W-1];
			acc_q <= '0;
			rem_q <= '0;
			unique case (op)
				MD_MUL: begin
					dv_q <= ma;
					sh_q <= {MUL_W'(mb), {(NUM_W-MUL_W){1'b0}}};
				end
				MD_DIV: begin
					dv_q <= mb;
					sh_q <= {ma, {FRAC_BITS{1'b0}}};
					// divide by zero saturates with the dividend's sign, or gives zero for a zero dividend
					if (a == '0) res_q <= '0;
					else res_q <= a[WIDE_W-1] ? -WIDE_LIM : WIDE_LIM;
				end
				default: begin
					dv_q  <= mb;
					neg_q <= 1'b0;
					sh_q  <= {a[MAG_W-1:0], {FRAC_BITS{1'b0}}};
					res_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				res_q <= res_fin;
			end else begin
				case (op_q)
					MD_MUL: begin
						acc_q <= acc_mul;
						sh_q  <= sh_q << 8;
					end
					MD_DIV: begin
						rem_q <= ge_div ? (t_div - {2'b00, dv_q}) : t_div;
						acc_q <= {acc_q[ACC_W-2:0], ge_div};
						sh_q  <= sh_q << 1;
					end
					default: begin
						rem_q <= ge_sq ? (t_sq - trial) : t_sq;
						acc_q <= {acc_q[ACC_W-2:0], ge_sq};
						sh_q  <= sh_q << 2;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

### rtl/grm_seq.sv
// microcode sequencer: program counter, step counter and march flags
`default_nettype none

module grm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [grm_pkg::MAXS_W-1:0] max_steps,
	input  grm_pkg::sts_t              sts,
	output grm_pkg::cw_t               cw,
	output grm_pkg::ctl_t              ctl
);
	import grm_pkg::*;

	seq_state_t        state_q, state_n;
	pc_t               pc_q, pc_n;
	logic [MAXS_W-1:0] cnt_q, cnt_n;
	logic              march_q, march_n, caught_q, caught_n;
	logic              take, is_long, is_alu;

	assign cw = ucode(pc_q);

	always_comb begin
		unique case (cw.cond)
			C_ALWAYS: take = 1'b1;
			C_MARCH:  take = march_q;
			C_LIMIT:  take = cnt_q >= max_steps;
			C_CAUGHT: take = caught_q;
			default:  take = 1'b0;
		endcase
	end

	always_comb begin
		is_long = 1'b0;
		is_alu  = 1'b0;
		unique case (cw.op) inside
			OP_MUL, OP_DIV, OP_SQRT:                        is_long = 1'b1;
			OP_LDIN, OP_ADD, OP_NEG, OP_HALF, OP_DECM, OP_CLW: is_alu = 1'b1;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_n  = state_q;
		pc_n     = pc_q;
		cnt_n    = cnt_q;
		march_n  = march_q;
		caught_n = caught_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n  = ST_FETCH;
					pc_n     = '0;
					cnt_n    = '0;
					march_n  = 1'b0;
					caught_n = 1'b0;
				end
			end
			ST_FETCH: begin
				unique case (cw.op) inside
					OP_NOP:    pc_n = take ? cw.target : pc_q + pc_t'(1);
					OP_FINISH: state_n = ST_FINISH;
					default:   state_n = ST_EXEC;
				endcase
			end
			ST_EXEC: begin
				if (is_long) begin
					state_n = ST_WAIT;
				end else begin
					state_n = ST_FETCH;
					pc_n    = pc_q + pc_t'(1);
					if (cw.op == OP_SETM) march_n = 1'b1;
					if (cw.op == OP_STEP) begin
						cnt_n    = cnt_q + MAXS_W'(1);
						caught_n = sts.capt;
					end
				end
			end
			ST_WAIT: begin
				if (sts.mdu_done) begin
					state_n = ST_FETCH;
					pc_n    = pc_q + pc_t'(1);
				end
			end
			ST_FINISH: begin
				if (sts.out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl          = '0;
		ctl.caught   = caught_q;
		ctl.steps    = cnt_q;
		unique case (state_q)
			ST_IDLE:   ctl.idle = 1'b1;
			ST_FETCH:  ctl.rd = (cw.op != OP_NOP) && (cw.op != OP_FINISH);
			ST_EXEC: begin
				ctl.wr_alu = is_alu;
				ctl.mdu_go = is_long;
			end
			ST_WAIT:   ctl.wr_mdu = sts.mdu_done;
			ST_FINISH: ctl.out_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pc_q     <= '0;
			cnt_q    <= '0;
			march_q  <= 1'b0;
			caught_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			pc_q     <= pc_n;
			cnt_q    <= cnt_n;
			march_q  <= march_n;
			caught_q <= caught_n;
		end
	end

endmodule

`default_nettype wire

### rtl/geodesic_ray_march_core.sv
// geodesic ray marcher: register file, simple ALU, config and item ports
// a run is a setup pass plus one pass per integration step; one item at a
// time, the next one is taken the cycle after the result is loaded, later
// if the output stalls; multiply, divide and root share the one iterative
// unit, each after its own fetch and operand read
// reset: config registers take their defaults, the sequencer idles
`default_nettype none

module geodesic_ray_march_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  grm_pkg::cidx_t              cfg_idx,
	input  logic [grm_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [grm_pkg::FIELD_W-1:0] start_x,
	input  logic signed [grm_pkg::FIELD_W-1:0] start_y,
	input  logic signed [grm_pkg::FIELD_W-1:0] start_z,
	input  logic signed [grm_pkg::FIELD_W-1:0] dir_x,
	input  logic signed [grm_pkg::FIELD_W-1:0] dir_y,
	input  logic signed [grm_pkg::FIELD_W-1:0] dir_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [grm_pkg::FIELD_W-1:0] end_x,
	output logic signed [grm_pkg::FIELD_W-1:0] end_y,
	output logic signed [grm_pkg::FIELD_W-1:0] end_z,
	output logic signed [grm_pkg::FIELD_W-1:0] vel_t,
	output logic signed [grm_pkg::FIELD_W-1:0] vel_x,
	output logic signed [grm_pkg::FIELD_W-1:0] vel_y,
	output logic signed [grm_pkg::FIELD_W-1:0] vel_z,
	output logic                        captured,
	output logic [grm_pkg::MAXS_W-1:0]  steps_used
);
	import grm_pkg::*;

	logic [STEP_W-1:0] step_size_q;
	logic [MAXS_W-1:0] max_steps_q;
	logic [CAP_W-1:0]  cap_q;

	logic signed [FIELD_W-1:0] in_q [NIN];
	wide_t rf_q [RF_DEPTH];
	wide_t res_q [NRES];
	wide_t opa_q, opb_q;
	logic  out_valid_q;

	cw_t     cw;
	ctl_t    ctl;
	sts_t    sts;
	mdu_op_t mop;
	wide_t   alu_res, half_t, decm_t, wdata, mdu_res;
	logic    mdu_done, accept, we;

	assign in_stall = !ctl.idle;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_RST;
			max_steps_q <= MAXS_RST;
			cap_q       <= CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_STEP: step_size_q <= cfg_data[STEP_W-1:0];
				CFG_MAXS: max_steps_q <= cfg_data[MAXS_W-1:0];
				CFG_CAP:  cap_q       <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= start_x;
			in_q[1] <= start_y;
			in_q[2] <= start_z;
			in_q[3] <= dir_x;
			in_q[4] <= dir_y;
			in_q[5] <= dir_z;
		end
	end

	grm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.max_steps (max_steps_q),
		.sts       (sts),
		.cw        (cw),
		.ctl       (ctl)
	);

	always_comb begin
		unique case (cw.op) inside
			OP_DIV:  mop = MD_DIV;
			OP_SQRT: mop = MD_SQRT;
			default: mop = MD_MUL;
		endcase
	end

	grm_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (ctl.mdu_go),
		.op     (mop),
		.a      (opa_q),
		.b      (opb_q),
		.done   (mdu_done),
		.res    (mdu_res)
	);

	always_comb begin
		half_t = opa_q + wide_t'(opa_q[WIDE_W-1]);
		decm_t = opa_q - ONE_Q;
		case (cw.op)
			OP_LDIN: alu_res = clamp_word(wide_t'(in_q[cw.sa[2:0]]));
			OP_ADD:  alu_res = sat_wide({opa_q[WIDE_W-1], opa_q} + {opb_q[WIDE_W-1], opb_q});
			OP_NEG:  alu_res = -opa_q;
			OP_HALF: alu_res = half_t >>> 1;
			// distance to the horizon, at least one lsb
			OP_DECM: alu_res = (decm_t < wide_t'(1)) ? wide_t'(1) : decm_t;
			OP_CLW:  alu_res = clamp_word(opa_q);
			default: alu_res = opa_q;
		endcase
	end

	assign we    = ctl.wr_alu || ctl.wr_mdu;
	assign wdata = ctl.wr_mdu ? mdu_res : alu_res;

	// register file with registered read; step size reads from config
	always_ff @(posedge clk) begin
		if (we) rf_q[cw.dst] <= wdata;
		if (ctl.rd) begin
			opa_q <= (cw.sa == A_H) ? wide_t'(step_size_q) : rf_q[cw.sa];
			opb_q <= (cw.sb == A_H) ? wide_t'(step_size_q) : rf_q[cw.sb];
		end
	end

	// copies of the result slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < NRES; i++) begin
			if (we && (cw.dst == addr_t'(i))) res_q[i] <= wdata;
		end
	end

	assign sts.mdu_done = mdu_done;
	assign sts.capt     = opa_q < wide_t'(cap_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			end_x      <= res_q[A_X[2:0]][FIELD_W-1:0];
			end_y      <= res_q[A_Y[2:0]][FIELD_W-1:0];
			end_z      <= res_q[A_Z[2:0]][FIELD_W-1:0];
			vel_t      <= res_q[A_VT[2:0]][FIELD_W-1:0];
			vel_x      <= res_q[A_VX[2:0]][FIELD_W-1:0];
			vel_y      <= res_q[A_VY[2:0]][FIELD_W-1:0];
			vel_z      <= res_q[A_VZ[2:0]][FIELD_W-1:0];
			captured   <= ctl.caught;
			steps_used <= ctl.steps;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
